### rtl/core/pnb_pkg.sv
// Shared constants and types for the banded 2-D gradient noise unit.
// No dependencies; imported by the channel interfaces and the top level.
package pnb_pkg;

	localparam int DEF_FRAC_BITS     = 12;
	localparam int DEF_OUT_FRAC_BITS = 12;
	localparam int TBL_W             = 8;
	localparam int TBL_DEPTH         = 256;
	localparam int LVL_W             = 5;
	localparam int BAND_W            = 3;
	localparam int CFG_IDX_W         = 3;
	localparam int LVL_LIMIT         = 10;

	typedef enum logic [CFG_IDX_W-1:0] {
		CFG_BAND_LIMIT_0 = 3'd0,
		CFG_BAND_LIMIT_1 = 3'd1,
		CFG_BAND_LIMIT_2 = 3'd2,
		CFG_BAND_LIMIT_3 = 3'd3
	} cfg_idx_t;

	typedef enum logic {
		OP_LOAD = 1'b0,
		OP_EVAL = 1'b1
	} opcode_t;

	localparam logic signed [LVL_W-1:0] BAND_LIMIT_0_RST = -5'sd3;
	localparam logic signed [LVL_W-1:0] BAND_LIMIT_1_RST = -5'sd2;
	localparam logic signed [LVL_W-1:0] BAND_LIMIT_2_RST = 5'sd1;
	localparam logic signed [LVL_W-1:0] BAND_LIMIT_3_RST = 5'sd4;

	localparam logic [BAND_W-1:0] BAND_0 = 3'd0;
	localparam logic [BAND_W-1:0] BAND_1 = 3'd1;
	localparam logic [BAND_W-1:0] BAND_2 = 3'd2;
	localparam logic [BAND_W-1:0] BAND_3 = 3'd3;
	localparam logic [BAND_W-1:0] BAND_4 = 3'd4;

endpackage

### rtl/core/pnb_if.sv
// Valid/ready channel interfaces for request and result items.
// Depends on pnb_pkg for field widths.
interface pnb_req_if import pnb_pkg::*; #(
	parameter int COORD_W = 8 + DEF_FRAC_BITS
);
	logic               valid;
	logic               ready;
	logic               opcode;
	logic [COORD_W-1:0] coord_x;
	logic [COORD_W-1:0] coord_y;
	logic [TBL_W-1:0]   table_index;
	logic [TBL_W-1:0]   table_value;

	modport source (output valid, opcode, coord_x, coord_y, table_index, table_value,
		input ready);
	modport sink (input valid, opcode, coord_x, coord_y, table_index, table_value,
		output ready);
endinterface

interface pnb_rsp_if import pnb_pkg::*; #(
	parameter int NV_W = 3 + DEF_OUT_FRAC_BITS
);
	logic                     valid;
	logic                     ready;
	logic signed [NV_W-1:0]   noise_value;
	logic signed [LVL_W-1:0]  noise_level;
	logic [BAND_W-1:0]        band_class;

	modport source (output valid, noise_value, noise_level, band_class, input ready);
	modport sink (input valid, noise_value, noise_level, band_class, output ready);
endinterface

### rtl/core/perlin_noise_2d_banding_unit.sv
// Banded 2-D gradient noise unit: six-stage pipeline over three copies of the
// permutation table. Depends on pnb_pkg and the channel interfaces in pnb_if.
// An accepted item passes through stages 0 to 5 into the result register; one item
// per cycle while results are taken. Stages advance together; a full result
// register that is not taken holds the whole pipe. Reset clears valids and
// restores the band limit defaults only; table contents are undefined until loaded.
module perlin_noise_2d_banding_unit import pnb_pkg::*; #(
	parameter int FRAC_BITS     = DEF_FRAC_BITS,
	parameter int OUT_FRAC_BITS = DEF_OUT_FRAC_BITS
) (
	input  logic                 clk,
	input  logic                 arst_n,
	pnb_req_if.sink              req,
	pnb_rsp_if.source            rsp,
	input  logic                 cfg_we,
	input  logic [CFG_IDX_W-1:0] cfg_index,
	input  logic [LVL_W-1:0]     cfg_data
);
	localparam int W     = FRAC_BITS + 8;
	localparam int NV_W  = 3 + OUT_FRAC_BITS;
	localparam int NW    = W + OUT_FRAC_BITS;
	localparam int LSH   = (OUT_FRAC_BITS >= FRAC_BITS) ? OUT_FRAC_BITS - FRAC_BITS : 0;
	localparam int RSH   = (OUT_FRAC_BITS >= FRAC_BITS) ? 0 : FRAC_BITS - OUT_FRAC_BITS;
	localparam int MW    = W + 4;
	localparam logic signed [W-1:0]  ONE_W  = W'(1) << FRAC_BITS;
	localparam logic signed [NW-1:0] NV_MAX = (NW'(1) << (NV_W - 1)) - NW'(1);
	localparam logic signed [NW-1:0] NV_MIN = -(NW'(1) << (NV_W - 1));

	function automatic logic signed [W-1:0] qmul(input logic signed [W-1:0] a,
		input logic signed [W-1:0] b);
		logic signed [2*W-1:0] p;
		p = a * b;
		return W'(p >>> FRAC_BITS);
	endfunction

	function automatic logic signed [W-1:0] grad(input logic [TBL_W-1:0] hash,
		input logic signed [W-1:0] dx, input logic signed [W-1:0] dy);
		logic [3:0] h;
		logic signed [W-1:0] p;
		logic signed [W-1:0] q;
		h = hash[3:0];
		p = h[3] ? dy : dx;
		if (h[3:2] == 2'b00)
			q = dy;
		else if (h == 4'd12 || h == 4'd14)
			q = dx;
		else
			q = '0;
		return (h[0] ? -p : p) + (h[1] ? -q : q);
	endfunction

	logic adv;
	logic out_valid_q;
	logic signed [NV_W-1:0]  nv_q;
	logic signed [LVL_W-1:0] lvl_q;
	logic [BAND_W-1:0]       band_q;
	logic signed [LVL_W-1:0] limit_q [4];

	assign adv       = !out_valid_q || rsp.ready;
	assign req.ready = adv;

	// band limit registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			limit_q[0] <= BAND_LIMIT_0_RST;
			limit_q[1] <= BAND_LIMIT_1_RST;
			limit_q[2] <= BAND_LIMIT_2_RST;
			limit_q[3] <= BAND_LIMIT_3_RST;
		end else if (cfg_we) begin
			case (cfg_idx_t'(cfg_index))
				CFG_BAND_LIMIT_0: limit_q[0] <= cfg_data;
				CFG_BAND_LIMIT_1: limit_q[1] <= cfg_data;
				CFG_BAND_LIMIT_2: limit_q[2] <= cfg_data;
				CFG_BAND_LIMIT_3: limit_q[3] <= cfg_data;
				default: ;
			endcase
		end
	end

	// ---------------- stage 0: first table level, fade start
	logic                 fire0;
	logic [TBL_W-1:0]     xi0, xi1_0, yi0;
	logic [FRAC_BITS-1:0] xf0, yf0;
	logic signed [W-1:0]  xfw0, yfw0;

	assign fire0 = req.valid && adv;
	assign xi0   = req.coord_x[FRAC_BITS +: TBL_W];
	assign xi1_0 = xi0 + TBL_W'(1);
	assign yi0   = req.coord_y[FRAC_BITS +: TBL_W];
	assign xf0   = req.coord_x[FRAC_BITS-1:0];
	assign yf0   = req.coord_y[FRAC_BITS-1:0];
	assign xfw0  = W'(xf0);
	assign yfw0  = W'(yf0);

	logic [TBL_W-1:0] mem_a [TBL_DEPTH];
	logic [TBL_W-1:0] mem_b [TBL_DEPTH];
	logic [TBL_W-1:0] mem_c [TBL_DEPTH];

	logic                 vld_s1, op_s1;
	logic [TBL_W-1:0]     pa_s1, pb_s1, yi_s1, tidx_s1, tval_s1;
	logic [FRAC_BITS-1:0] xf_s1, yf_s1;
	logic signed [W-1:0]  bx_s1, by_s1, t2x_s1, t2y_s1;

	always_ff @(posedge clk) begin
		if (fire0 && req.opcode == OP_LOAD)
			mem_a[req.table_index] <= req.table_value;
		if (adv) begin
			pa_s1 <= mem_a[xi0];
			pb_s1 <= mem_a[xi1_0];
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			op_s1   <= req.opcode;
			yi_s1   <= yi0;
			tidx_s1 <= req.table_index;
			tval_s1 <= req.table_value;
			xf_s1   <= xf0;
			yf_s1   <= yf0;
			bx_s1   <= qmul(xfw0, W'((xfw0 <<< 2) + (xfw0 <<< 1) - 15 * ONE_W));
			by_s1   <= qmul(yfw0, W'((yfw0 <<< 2) + (yfw0 <<< 1) - 15 * ONE_W));
			t2x_s1  <= qmul(xfw0, xfw0);
			t2y_s1  <= qmul(yfw0, yfw0);
		end
	end

	// ---------------- stage 1: second table level
	logic [TBL_W-1:0] ha1, hb1;
	assign ha1 = pa_s1 + yi_s1;
	assign hb1 = pb_s1 + yi_s1;

	logic                 vld_s2;
	logic [TBL_W-1:0]     aa_s2, ab_s2, ba_s2, bb_s2;
	logic [FRAC_BITS-1:0] xf_s2, yf_s2;
	logic signed [W-1:0]  cx_s2, cy_s2, t3x_s2, t3y_s2;

	// loads reach the second-level copies in item order
	always_ff @(posedge clk) begin
		if (adv && vld_s1 && op_s1 == OP_LOAD) begin
			mem_b[tidx_s1] <= tval_s1;
			mem_c[tidx_s1] <= tval_s1;
		end
		if (adv) begin
			aa_s2 <= mem_b[ha1];
			ab_s2 <= mem_b[ha1 + TBL_W'(1)];
			ba_s2 <= mem_c[hb1];
			bb_s2 <= mem_c[hb1 + TBL_W'(1)];
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			xf_s2  <= xf_s1;
			yf_s2  <= yf_s1;
			cx_s2  <= W'(bx_s1 + 10 * ONE_W);
			cy_s2  <= W'(by_s1 + 10 * ONE_W);
			t3x_s2 <= qmul(t2x_s1, W'(xf_s1));
			t3y_s2 <= qmul(t2y_s1, W'(yf_s1));
		end
	end

	// ---------------- stage 2: gradients, fade end
	logic signed [W-1:0] dx2, dy2;
	assign dx2 = W'(xf_s2);
	assign dy2 = W'(yf_s2);

	logic                vld_s3;
	logic signed [W-1:0] u_s3, v_s3, gaa_s3, gab_s3, gba_s3, gbb_s3;

	always_ff @(posedge clk) begin
		if (adv) begin
			u_s3   <= qmul(t3x_s2, cx_s2);
			v_s3   <= qmul(t3y_s2, cy_s2);
			gaa_s3 <= grad(aa_s2, dx2, dy2);
			gba_s3 <= grad(ba_s2, dx2 - ONE_W, dy2);
			gab_s3 <= grad(ab_s2, dx2, dy2 - ONE_W);
			gbb_s3 <= grad(bb_s2, dx2 - ONE_W, dy2 - ONE_W);
		end
	end

	// ---------------- stage 3: x interpolation products
	logic                vld_s4;
	logic signed [W-1:0] p1_s4, p2_s4, gaa_s4, gab_s4, v_s4;

	always_ff @(posedge clk) begin
		if (adv) begin
			p1_s4  <= qmul(u_s3, gba_s3 - gaa_s3);
			p2_s4  <= qmul(u_s3, gbb_s3 - gab_s3);
			gaa_s4 <= gaa_s3;
			gab_s4 <= gab_s3;
			v_s4   <= v_s3;
		end
	end

	// ---------------- stage 4: y interpolation product
	logic signed [W-1:0] x1_4, x2_4;
	assign x1_4 = gaa_s4 + p1_s4;
	assign x2_4 = gab_s4 + p2_s4;

	logic                vld_s5;
	logic signed [W-1:0] x1_s5, py_s5;

	always_ff @(posedge clk) begin
		if (adv) begin
			x1_s5 <= x1_4;
			py_s5 <= qmul(v_s4, x2_4 - x1_4);
		end
	end

	// ---------------- stage 5: output format, level, band
	logic signed [W-1:0]     n5;
	logic signed [NW-1:0]    ne5, ow5;
	logic signed [NV_W-1:0]  nv5;
	logic signed [MW-1:0]    m5;
	logic [MW-1:0]           mag5, q5;
	logic [LVL_W-1:0]        qs5;
	logic signed [LVL_W-1:0] lvl5;
	logic [BAND_W-1:0]       band5;

	always_comb begin
		n5  = x1_s5 + py_s5;
		ne5 = NW'(n5);
		ow5 = (ne5 <<< LSH) >>> RSH;
		if (ow5 > NV_MAX)
			nv5 = NV_W'(NV_MAX);
		else if (ow5 < NV_MIN)
			nv5 = NV_W'(NV_MIN);
		else
			nv5 = NV_W'(ow5);
		m5   = MW'(n5) * MW'(10);
		mag5 = m5[MW-1] ? MW'(-m5) : MW'(m5);
		q5   = mag5 >> FRAC_BITS;
		qs5  = (q5 > MW'(LVL_LIMIT)) ? LVL_W'(LVL_LIMIT) : q5[LVL_W-1:0];
		lvl5 = m5[MW-1] ? -$signed(qs5) : $signed(qs5);
		if (lvl5 < limit_q[0])
			band5 = BAND_0;
		else if (lvl5 < limit_q[1])
			band5 = BAND_1;
		else if (lvl5 < limit_q[2])
			band5 = BAND_2;
		else if (lvl5 < limit_q[3])
			band5 = BAND_3;
		else
			band5 = BAND_4;
	end

	logic op_s2, op_s3, op_s4, op_s5;

	always_ff @(posedge clk) begin
		if (adv) begin
			op_s2 <= op_s1;
			op_s3 <= op_s2;
			op_s4 <= op_s3;
			op_s5 <= op_s4;
			nv_q   <= nv5;
			lvl_q  <= lvl5;
			band_q <= band5;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1      <= 1'b0;
			vld_s2      <= 1'b0;
			vld_s3      <= 1'b0;
			vld_s4      <= 1'b0;
			vld_s5      <= 1'b0;
			out_valid_q <= 1'b0;
		end else if (adv) begin
			vld_s1      <= req.valid;
			vld_s2      <= vld_s1;
			vld_s3      <= vld_s2;
			vld_s4      <= vld_s3;
			vld_s5      <= vld_s4;
			out_valid_q <= vld_s5 && op_s5 == OP_EVAL;
		end
	end

	assign rsp.valid       = out_valid_q;
	assign rsp.noise_value = nv_q;
	assign rsp.noise_level = lvl_q;
	assign rsp.band_class  = band_q;

`ifndef ASSERT_OFF
	a_out_from_eval: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid_q) |-> $past(vld_s5 && op_s5 == OP_EVAL))
		else $error("result raised without an evaluate item in last stage");
	a_level_range: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q |-> (lvl_q >= -5'sd10 && lvl_q <= 5'sd10))
		else $error("noise level out of range");
	a_band_range: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q |-> band_q <= BAND_4)
		else $error("band index out of range");
	a_stall_hold: assert property (@(posedge clk) disable iff (!arst_n)
		!adv |=> $stable(vld_s5) && $stable(op_s5))
		else $error("pipeline moved while stalled");
`endif

endmodule
